>>> rtl/core/cidv_pkg.sv
// ----------------------------------------------------------------------------
// cidv_pkg
// Shared types, constants and keyword table for the C identifier validator.
// ----------------------------------------------------------------------------
package cidv_pkg;

    localparam int PREFIX_DEPTH   = 8;
    localparam int COUNT_SAT      = 9;
    localparam int KEYWORD_TOTAL  = 32;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_ZERO       = 8'h30;
    localparam logic [7:0] CHAR_NINE       = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z    = 8'h7A;

    typedef enum logic [1:0] {
        VERDICT_VALID   = 2'd0,
        VERDICT_KEYWORD = 2'd1,
        VERDICT_ILLEGAL = 2'd2,
        VERDICT_DIGIT   = 2'd3
    } verdict_t;

    // one finished name, first byte in the top bits, unused bytes zero
    typedef struct packed {
        logic [8*PREFIX_DEPTH-1:0] prefix;
        logic [3:0]                count;
        logic                      bad_char;
        logic                      lead_digit;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    // keywords left-justified in a 64-bit word, zero padded
    function automatic logic [63:0] kw_word(input logic [4:0] k);
        logic [63:0] w;
        unique case (k)
            5'd0:  w = {"auto", 32'h0};
            5'd1:  w = {"break", 24'h0};
            5'd2:  w = {"case", 32'h0};
            5'd3:  w = {"char", 32'h0};
            5'd4:  w = {"const", 24'h0};
            5'd5:  w = "continue";
            5'd6:  w = {"default", 8'h0};
            5'd7:  w = {"do", 48'h0};
            5'd8:  w = {"double", 16'h0};
            5'd9:  w = {"else", 32'h0};
            5'd10: w = {"enum", 32'h0};
            5'd11: w = {"extern", 16'h0};
            5'd12: w = {"float", 24'h0};
            5'd13: w = {"for", 40'h0};
            5'd14: w = {"goto", 32'h0};
            5'd15: w = {"if", 48'h0};
            5'd16: w = {"int", 40'h0};
            5'd17: w = {"long", 32'h0};
            5'd18: w = "register";
            5'd19: w = {"return", 16'h0};
            5'd20: w = {"short", 24'h0};
            5'd21: w = {"signed", 16'h0};
            5'd22: w = {"sizeof", 16'h0};
            5'd23: w = {"static", 16'h0};
            5'd24: w = {"struct", 16'h0};
            5'd25: w = {"switch", 16'h0};
            5'd26: w = {"typedef", 8'h0};
            5'd27: w = {"union", 24'h0};
            5'd28: w = "unsigned";
            5'd29: w = {"void", 32'h0};
            5'd30: w = "volatile";
            default: w = {"while", 24'h0};
        endcase
        return w;
    endfunction

    function automatic logic [3:0] kw_len(input logic [4:0] k);
        logic [3:0] n;
        unique case (k)
            5'd7, 5'd15:                               n = 4'd2;
            5'd13, 5'd16:                              n = 4'd3;
            5'd0, 5'd2, 5'd3, 5'd9, 5'd10, 5'd14,
            5'd17, 5'd29:                              n = 4'd4;
            5'd1, 5'd4, 5'd12, 5'd20, 5'd27, 5'd31:    n = 4'd5;
            5'd8, 5'd11, 5'd19, 5'd21, 5'd22, 5'd23,
            5'd24, 5'd25:                              n = 4'd6;
            5'd6, 5'd26:                               n = 4'd7;
            default:                                   n = 4'd8;
        endcase
        return n;
    endfunction

endpackage

>>> rtl/core/cidv_front.sv
// ----------------------------------------------------------------------------
// cidv_front
// Takes one character per word, keeps prefix, count and fault flags, and
// hands a finished name to the queue on the last character.
// ----------------------------------------------------------------------------
module cidv_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] character
    input  logic                 s_tlast,   // last_char
    input  cidv_pkg::queue_stat_t q_stat,
    output logic                 push,
    output cidv_pkg::job_t       push_job
);
    import cidv_pkg::*;

    logic [7:0] prefix_reg [PREFIX_DEPTH];
    logic [7:0] prefix_next [PREFIX_DEPTH];
    logic [3:0] count_reg, count_next;
    logic       bad_reg, bad_next;
    logic       digit_reg, digit_next;
    logic       accept;
    logic       is_digit, is_legal;

    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        is_digit = (s_tdata >= CHAR_ZERO) && (s_tdata <= CHAR_NINE);
        is_legal = is_digit || (s_tdata == CHAR_UNDERSCORE) ||
                   ((s_tdata >= CHAR_UPPER_A) && (s_tdata <= CHAR_UPPER_Z)) ||
                   ((s_tdata >= CHAR_LOWER_A) && (s_tdata <= CHAR_LOWER_Z));
    end

    // state after absorbing the current character
    always_comb begin
        for (int i = 0; i < PREFIX_DEPTH; i++) begin
            prefix_next[i] = prefix_reg[i];
            if ((count_reg == 4'(i)) && accept) begin
                prefix_next[i] = s_tdata;
            end
        end
        count_next = count_reg;
        bad_next   = bad_reg;
        digit_next = digit_reg;
        if (accept) begin
            if (count_reg < 4'(COUNT_SAT)) begin
                count_next = count_reg + 4'd1;
            end
            if (!is_legal) begin
                bad_next = 1'b1;
            end
            if ((count_reg == 4'd0) && is_digit) begin
                digit_next = 1'b1;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < PREFIX_DEPTH; i++) begin
            push_job.prefix[8*(PREFIX_DEPTH-i)-1 -: 8] = prefix_next[i];
        end
        push_job.count      = count_next;
        push_job.bad_char   = bad_next;
        push_job.lead_digit = digit_next;
    end

    assign push = accept && s_tlast;

    always_ff @(posedge aclk) begin
        if (!aresetn || push) begin
            for (int i = 0; i < PREFIX_DEPTH; i++) begin
                prefix_reg[i] <= 8'h00;
            end
            count_reg <= 4'd0;
            bad_reg   <= 1'b0;
            digit_reg <= 1'b0;
        end else begin
            for (int i = 0; i < PREFIX_DEPTH; i++) begin
                prefix_reg[i] <= prefix_next[i];
            end
            count_reg <= count_next;
            bad_reg   <= bad_next;
            digit_reg <= digit_next;
        end
    end

endmodule

>>> rtl/core/cidv_queue.sv
// ----------------------------------------------------------------------------
// cidv_queue
// Small first-in first-out queue of finished names between front and back.
// ----------------------------------------------------------------------------
module cidv_queue #(
    parameter int DEPTH = cidv_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  cidv_pkg::job_t        push_job,
    input  logic                  pop,
    output cidv_pkg::job_t        pop_job,
    output cidv_pkg::queue_stat_t q_stat,
    output logic [$clog2(DEPTH+1)-1:0] level
);
    import cidv_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH+1);

    job_t            mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [LW-1:0]   level_reg;

    assign level        = level_reg;
    assign q_stat.full  = (level_reg == LW'(DEPTH));
    assign q_stat.empty = (level_reg == '0);
    assign pop_job      = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (push && !pop) begin
                level_reg <= level_reg + LW'(1);
            end else if (pop && !push) begin
                level_reg <= level_reg - LW'(1);
            end
        end
    end

endmodule

>>> rtl/core/cidv_back.sv
// ----------------------------------------------------------------------------
// cidv_back
// Matches a queued name against the keyword table, ranks the faults and
// holds the verdict in the output register.
// ----------------------------------------------------------------------------
module cidv_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cidv_pkg::queue_stat_t q_stat,
    input  cidv_pkg::job_t        pop_job,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata   // [1:0] verdict, [2] is_valid
);
    import cidv_pkg::*;

    logic     valid_reg;
    verdict_t verdict_reg, verdict_next;
    logic     kw_hit;

    assign pop = !q_stat.empty && (!valid_reg || m_tready);

    // unused prefix bytes are zero, so a padded compare plus length bound matches
    always_comb begin
        kw_hit = 1'b0;
        for (int k = 0; k < KEYWORD_TOTAL; k++) begin
            if ((pop_job.prefix == kw_word(5'(k))) &&
                (pop_job.count >= kw_len(5'(k))) &&
                (pop_job.count <= 4'(PREFIX_DEPTH))) begin
                kw_hit = 1'b1;
            end
        end
    end

    always_comb begin
        if (kw_hit) begin
            verdict_next = VERDICT_KEYWORD;
        end else if (pop_job.bad_char) begin
            verdict_next = VERDICT_ILLEGAL;
        end else if (pop_job.lead_digit) begin
            verdict_next = VERDICT_DIGIT;
        end else begin
            verdict_next = VERDICT_VALID;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            verdict_reg <= verdict_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'd0, (verdict_reg == VERDICT_VALID), verdict_reg};

endmodule

>>> rtl/core/c_identifier_validator.sv
// ----------------------------------------------------------------------------
// c_identifier_validator
// Classifies a streamed candidate name as valid C identifier, C89 keyword,
// name with an illegal character, or name with a leading digit.
// ----------------------------------------------------------------------------
// One character is taken per word on the s_ side, at one word per cycle; the
// word with tlast closes the name. The front keeps the first eight characters
// and the fault flags and queues the finished name; the back compares it with
// the 32 keywords and registers the verdict for m_ as it pops the name from
// the queue. Only words carrying tlast produce a result. The
// input stalls only when QUEUE_DEPTH finished names are waiting behind a
// stalled output, so with m_tready high the block sustains one character per
// cycle, names of any length back to back.
// ----------------------------------------------------------------------------
module c_identifier_validator #(
    parameter int QUEUE_DEPTH = cidv_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] character
    input  logic       s_tlast,   // last_char
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [1:0] verdict, [2] is_valid, [7:3] zero
);
    import cidv_pkg::*;

    localparam int LW = $clog2(QUEUE_DEPTH+1);

    job_t        push_job, pop_job;
    queue_stat_t q_stat;
    logic        push, pop;
    logic [LW-1:0] level;

    cidv_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_stat   (q_stat),
        .push     (push),
        .push_job (push_job)
    );

    cidv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .q_stat   (q_stat),
        .level    (level)
    );

    cidv_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .pop_job  (pop_job),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // verdict flag and code agree, pad bits stay clear
    a_flag_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[2] == (m_tdata[1:0] == VERDICT_VALID)) &&
                      (m_tdata[7:3] == 5'd0)))
        else $error("verdict flag mismatch");

    // queue level never passes its depth
    a_level: assert property (@(posedge aclk) disable iff (!aresetn)
        level <= LW'(QUEUE_DEPTH))
        else $error("queue overflow");

    // a closed name is waiting in the queue on the next cycle
    a_name_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !q_stat.empty)
        else $error("closed name lost");

    // no pop from an empty queue
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (level != '0))
        else $error("pop from empty queue");

endmodule
